[rtl/core/dlefrc_pkg.sv]
// shared types and constants of the dle frame receiver and checker
package dlefrc_pkg;

    localparam logic [7:0] MARK_STX = 8'h02;
    localparam logic [7:0] MARK_ETX = 8'h03;
    localparam logic [7:0] MARK_DLE = 8'h10;

    localparam int unsigned CFG_W   = 15;
    localparam int unsigned TDATA_W = 72;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_CHECKSUM = 3'd1,
        STAT_LENGTH   = 3'd2,
        STAT_TRUNC    = 3'd3,
        STAT_OVERRUN  = 3'd4
    } status_t;

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  body_byte;
        logic [14:0] body_index;
        status_t     status;
        logic [7:0]  seq_counter;
        logic [7:0]  msg_type;
        logic [7:0]  unit_number;
        logic [1:0]  response_kind;
        logic [15:0] body_length;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t data;
    } result_bus_t;

endpackage

[rtl/core/dlefrc_parse.sv]
// frame hunting, destuffing, header parsing and end-of-frame verdict
module dlefrc_parse
    import dlefrc_pkg::*;
#(
    parameter int unsigned MAX_FRAME_LEN = 4096
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             acc,
    input  logic [7:0]       rx_byte,
    input  logic             cfg_valid,
    input  logic [CFG_W-1:0] cfg_data,
    output result_bus_t      res
);

    localparam int unsigned POS_W = $clog2(MAX_FRAME_LEN + 1);
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_FRAME_LEN);

    localparam logic [7:0] CH_LA = "a";
    localparam logic [7:0] CH_LN = "n";
    localparam logic [7:0] CH_LB = "b";
    localparam logic [7:0] CH_LQ = "q";
    localparam logic [7:0] CH_LC = "c";
    localparam logic [7:0] CH_LF = "f";
    localparam logic [7:0] CH_UA = "A";
    localparam logic [7:0] CH_UN = "N";
    localparam logic [7:0] CH_UB = "B";
    localparam logic [7:0] CH_UF = "F";

    typedef enum logic [2:0] {
        ST_HUNT0 = 3'b001,
        ST_HUNT1 = 3'b010,
        ST_FRAME = 3'b100
    } state_t;

    function automatic logic has_unit(input logic [7:0] t);
        has_unit = (t == CH_LA) || (t == CH_LN) || (t == CH_LB) ||
                   (t == CH_LQ) || (t == CH_LC) || (t == CH_LF);
    endfunction

    state_t           state_reg, state_next;
    logic             esc_reg, esc_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [31:0]      sum_reg, sum_next;
    logic [31:0]      lf_reg, lf_next;
    logic [7:0]       cnt_reg, cnt_next;
    logic [7:0]       type_reg, type_next;
    logic [7:0]       unit_reg, unit_next;
    logic [15:0]      len_reg, len_next;
    logic             ovr_reg, ovr_next;
    logic             len_err_reg, len_err_next;
    logic [1:0]       kept_rk_reg, kept_rk_next;
    logic [7:0]       kept_unit_reg, kept_unit_next;
    logic [CFG_W-1:0] max_len_reg;

    logic             store;
    logic             do_verdict;
    logic [POS_W-1:0] hs;
    logic [POS_W-1:0] body_off;
    logic [15:0]      new_len;
    logic             hdr_len_bad;
    status_t          verdict_st;

    always_comb begin
        state_next     = state_reg;
        esc_next       = esc_reg;
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        lf_next        = lf_reg;
        cnt_next       = cnt_reg;
        type_next      = type_reg;
        unit_next      = unit_reg;
        len_next       = len_reg;
        ovr_next       = ovr_reg;
        len_err_next   = len_err_reg;
        kept_rk_next   = kept_rk_reg;
        kept_unit_next = kept_unit_reg;
        store          = 1'b0;
        do_verdict     = 1'b0;
        verdict_st     = STAT_OK;
        res.valid      = 1'b0;

        hs          = has_unit(type_reg) ? POS_W'(5) : POS_W'(4);
        body_off    = pos_reg - hs;
        new_len     = {rx_byte, len_reg[7:0]};
        hdr_len_bad = len_reg[15] || (len_reg[14:0] > max_len_reg);

        if (acc) begin
            unique case (state_reg)
                ST_HUNT0: begin
                    if (rx_byte == MARK_STX) begin
                        state_next = ST_HUNT1;
                    end
                end
                ST_HUNT1: begin
                    if (rx_byte == MARK_STX) begin
                        state_next   = ST_FRAME;
                        esc_next     = 1'b0;
                        pos_next     = '0;
                        sum_next     = '0;
                        lf_next      = '0;
                        cnt_next     = '0;
                        type_next    = '0;
                        unit_next    = '0;
                        len_next     = '0;
                        ovr_next     = 1'b0;
                        len_err_next = 1'b0;
                    end
                end
                ST_FRAME: begin
                    if (esc_reg) begin
                        esc_next = 1'b0;
                        store    = 1'b1;
                    end else if (rx_byte == MARK_DLE) begin
                        esc_next = 1'b1;
                    end else if (rx_byte == MARK_ETX) begin
                        do_verdict = 1'b1;
                        state_next = ST_HUNT0;
                    end else if (rx_byte != MARK_STX) begin
                        store = 1'b1;
                    end
                end
                default: begin
                    state_next = ST_HUNT0;
                end
            endcase
        end

        if (store) begin
            if (pos_reg >= MAX_POS) begin
                ovr_next = 1'b1;
            end else begin
                sum_next = sum_reg + 32'(lf_reg[7:0]);
                lf_next  = {rx_byte, lf_reg[31:8]};
                pos_next = pos_reg + POS_W'(1);
                if (pos_reg == POS_W'(0)) begin
                    cnt_next = rx_byte;
                end else if (pos_reg == POS_W'(1)) begin
                    type_next = rx_byte;
                end else if (pos_reg < hs) begin
                    if ((hs == POS_W'(5)) && (pos_reg == POS_W'(2))) begin
                        unit_next = rx_byte;
                    end else if (pos_reg == hs - POS_W'(2)) begin
                        len_next[7:0] = rx_byte;
                    end else begin
                        len_next[15:8] = rx_byte;
                        if (new_len[15] || (new_len[14:0] > max_len_reg)) begin
                            len_err_next = 1'b1;
                        end
                    end
                end else if (!len_err_reg && (17'(body_off) < 17'(len_reg))) begin
                    res.valid = 1'b1;
                end
            end
        end

        if (do_verdict) begin
            res.valid = 1'b1;
            if (ovr_reg) begin
                verdict_st = STAT_OVERRUN;
            end else if (pos_reg < POS_W'(4)) begin
                verdict_st = STAT_TRUNC;
            end else if (sum_reg != lf_reg) begin
                verdict_st = STAT_CHECKSUM;
            end else if (17'(pos_reg) < 17'(hs) + 17'd4) begin
                verdict_st = STAT_TRUNC;
            end else begin
                if (has_unit(type_reg)) begin
                    kept_unit_next = unit_reg;
                end
                case (type_reg) inside
                    CH_UA, CH_LA, CH_UN, CH_LN, CH_UB, CH_LB: kept_rk_next = 2'd1;
                    CH_LC, CH_UF, CH_LF:                      kept_rk_next = 2'd2;
                    default:                                  kept_rk_next = kept_rk_reg;
                endcase
                if (hdr_len_bad) begin
                    verdict_st = STAT_LENGTH;
                end else if (17'(pos_reg) < 17'(hs) + 17'(len_reg) + 17'd4) begin
                    verdict_st = STAT_TRUNC;
                end else begin
                    verdict_st = STAT_OK;
                end
            end
        end

        res.data.item_kind     = do_verdict;
        res.data.body_byte     = do_verdict ? 8'h00 : rx_byte;
        res.data.body_index    = do_verdict ? 15'd0 : 15'(body_off);
        res.data.status        = verdict_st;
        res.data.seq_counter   = cnt_reg;
        res.data.msg_type      = type_reg;
        res.data.unit_number   = kept_unit_next;
        res.data.response_kind = kept_rk_next;
        res.data.body_length   = len_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_HUNT0;
            esc_reg       <= 1'b0;
            pos_reg       <= '0;
            sum_reg       <= '0;
            lf_reg        <= '0;
            cnt_reg       <= '0;
            type_reg      <= '0;
            unit_reg      <= '0;
            len_reg       <= '0;
            ovr_reg       <= 1'b0;
            len_err_reg   <= 1'b0;
            kept_rk_reg   <= '0;
            kept_unit_reg <= '0;
            max_len_reg   <= CFG_W'(4096);
        end else begin
            state_reg     <= state_next;
            esc_reg       <= esc_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            lf_reg        <= lf_next;
            cnt_reg       <= cnt_next;
            type_reg      <= type_next;
            unit_reg      <= unit_next;
            len_reg       <= len_next;
            ovr_reg       <= ovr_next;
            len_err_reg   <= len_err_next;
            kept_rk_reg   <= kept_rk_next;
            kept_unit_reg <= kept_unit_next;
            if (cfg_valid) begin
                max_len_reg <= cfg_data;
            end
        end
    end

`ifndef SYNTH
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= MAX_POS)
        else $error("frame position past limit");

    a_verdict_rehunt: assert property (@(posedge aclk) disable iff (!aresetn)
        (res.valid && res.data.item_kind) |=> (state_reg == ST_HUNT0))
        else $error("verdict did not restart hunting");

    a_body_len_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (res.valid && !res.data.item_kind) |-> (!len_err_reg && !len_reg[15]))
        else $error("body word with invalid length");

    a_body_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (res.valid && !res.data.item_kind) |-> (state_reg == ST_FRAME))
        else $error("body word outside a frame");
`endif

endmodule

[rtl/core/dlefrc_out_reg.sv]
// result register and output stream packing
module dlefrc_out_reg
    import dlefrc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  result_bus_t        res,
    input  logic               acc,
    output logic               res_ready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tlast,
    output logic [0:0]         m_tuser
);

    logic    valid_reg;
    result_t data_reg;

    assign res_ready = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_ready) begin
            valid_reg <= acc && res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready) begin
            data_reg <= res.data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = data_reg.item_kind;
    assign m_tuser  = data_reg.item_kind;
    assign m_tdata  = {4'h0,
                       data_reg.body_length,
                       data_reg.response_kind,
                       data_reg.unit_number,
                       data_reg.msg_type,
                       data_reg.seq_counter,
                       data_reg.status,
                       data_reg.body_index,
                       data_reg.body_byte};

endmodule

[rtl/core/dle_frame_receiver_checker_core.sv]
// top level of the dle frame receiver and checker
// s_ channel: one raw line byte per word; bytes are dropped until two stx
// marks arrive, then dle escapes are removed and an unescaped etx ends the frame.
// m_ channel: one word per emitted body byte (tuser 0) and one end-of-frame
// verdict word per frame (tuser 1, tlast 1) carrying status and header fields.
// body words stream out before the verdict, so a consumer keeps them only
// when the verdict status is ok.
// cfg_ channel: writes max_body_len; cfg_ready is always high, write only
// while no frame is in progress.
// a result word is registered and appears on m_ in the cycle after its byte is taken.
// throughput: one byte per cycle while the result register can take a new word;
// a stalled m_ side holds the result register and s_tready drops with it;
// when the result register is draining or empty a new byte is taken at once.
// reset: hunts for stx, max_body_len returns to 4096, kept unit and
// response kind return to zero, no word is pending.
module dle_frame_receiver_checker_core
    import dlefrc_pkg::*;
#(
    parameter int unsigned MAX_FRAME_LEN = 4096
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // rx_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    // body_byte, body_index, status, seq_counter, msg_type, unit_number,
    // response_kind, body_length, zero fill
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tlast,   // last_of_frame
    output logic [0:0]         m_tuser,   // item_kind
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CFG_W-1:0]   cfg_data   // max_body_len
);

    result_bus_t res;
    logic        res_ready;
    logic        acc;

    assign s_tready  = res_ready;
    assign acc       = s_tvalid && res_ready;
    assign cfg_ready = 1'b1;

    dlefrc_parse #(
        .MAX_FRAME_LEN(MAX_FRAME_LEN)
    ) u_parse (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .acc      (acc),
        .rx_byte  (s_tdata),
        .cfg_valid(cfg_valid),
        .cfg_data (cfg_data),
        .res      (res)
    );

    dlefrc_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res      (res),
        .acc      (acc),
        .res_ready(res_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
